@@ rtl/http_chunked_body_decoder_core_macros.svh @@
// ----------------------------------------------------------------------------
// http chunked body decoder assertion macros
// shorthand for clocked concurrent checks with an active-low reset
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH

// property must hold at every rising edge out of reset
`define HCBD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the following edge
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hcbd_pkg.sv @@
// ----------------------------------------------------------------------------
// hcbd_pkg
// shared constants and helpers for the http chunked body decoder
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int unsigned ByteW          = 8;
  localparam int unsigned SizeBitsDefault = 32;
  localparam int unsigned UserW          = 2;

  // tuser bit positions on the result side
  localparam int unsigned UserHasByte = 0;
  localparam int unsigned UserStatus  = 1;

  localparam logic [ByteW-1:0] CharCr = 8'h0D;
  localparam logic [ByteW-1:0] CharLf = 8'h0A;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // ascii hex digit decode: 0-9, a-f, A-F
  function automatic hex_t hex_decode(input logic [ByteW-1:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

@@ rtl/http_chunked_body_decoder_core.sv @@
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// strips chunk framing from an http chunked body; unless stalled, one byte per clock
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up) | tuser (low bit up)        | tlast
//  s_axis   | in  | in_byte[7:0]       | -                         | in_last
//  m_axis   | out | out_byte[7:0]      | out_has_byte, out_status  | out_end
//
//  flow: one byte per clock unless stalled; a request passes the input and
//  then the result register; the payload count decrement is the deepest path
//  reset: rst_ni clears phase, chunk count and flags; decoding restarts at a
//  size line
//  stalls: while a result waits, the input register takes at most one more
//  request, then s_axis_tready stays low until m_axis_tready takes the result
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core #(
  parameter int unsigned SizeBits = hcbd_pkg::SizeBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input request
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [hcbd_pkg::ByteW-1:0]  s_axis_tdata,   // in_byte[7:0]
  input  logic                        s_axis_tlast,   // in_last
  // result request
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [hcbd_pkg::ByteW-1:0]  m_axis_tdata,   // out_byte[7:0]
  output logic [hcbd_pkg::UserW-1:0]  m_axis_tuser,   // out_has_byte, out_status
  output logic                        m_axis_tlast    // out_end
);
  import hcbd_pkg::*;

  // decoder phases
  localparam logic [1:0] PhSize = 2'd0;  // parsing a chunk-size line
  localparam logic [1:0] PhData = 2'd1;  // passing payload bytes
  localparam logic [1:0] PhSkip = 2'd2;  // dropping the two bytes after data
  localparam logic [1:0] PhDone = 2'd3;  // body finished, ignore everything

  // input register
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;

  // decoder state
  logic [1:0]          phase_q, phase_d;
  logic [SizeBits-1:0] left_q, left_d;
  logic                digits_done_q, digits_done_d;
  logic                saw_cr_q, saw_cr_d;
  logic [1:0]          skip_q, skip_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q;
  logic             out_has_q, out_end_q, out_status_q;

  // result being formed for the byte in the input register
  logic             emit;
  logic [ByteW-1:0] r_byte;
  logic             r_has, r_end, r_status;

  logic                in_take, proc_go;
  hex_t                hex;
  logic [SizeBits-1:0] size_next, left_dec;

  // a byte moves on once the result slot is free or draining this cycle
  assign proc_go       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc_go;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign hex = hex_decode(in_byte_q);

  // size accumulate: anything spilling past the top nibble saturates
  always_comb begin
    if (left_q[SizeBits-1 -: 4] != 4'd0) begin
      size_next = '1;
    end else begin
      size_next = {left_q[SizeBits-5:0], hex.val};
    end
  end

  assign left_dec = (left_q != '0) ? left_q - 1'b1 : left_q;

  always_comb begin
    phase_d       = phase_q;
    left_d        = left_q;
    digits_done_d = digits_done_q;
    saw_cr_d      = saw_cr_q;
    skip_d        = skip_q;
    emit          = 1'b0;
    r_byte        = '0;
    r_has         = 1'b0;
    r_end         = 1'b0;
    r_status      = 1'b0;

    if (proc_go) begin
      unique case (phase_q)
        PhSize: begin
          if (saw_cr_q && in_byte_q == CharLf) begin
            // end of size line
            saw_cr_d      = 1'b0;
            digits_done_d = 1'b0;
            if (left_q == '0) begin
              // zero or empty size closes the body cleanly
              phase_d = PhDone;
              emit    = 1'b1;
              r_end   = 1'b1;
            end else begin
              phase_d = PhData;
            end
          end else begin
            if (!digits_done_q && hex.ok) begin
              left_d = size_next;
            end else begin
              digits_done_d = 1'b1;
            end
            saw_cr_d = (in_byte_q == CharCr);
          end
        end
        PhData: begin
          if (left_q != '0) begin
            emit   = 1'b1;
            r_has  = 1'b1;
            r_byte = in_byte_q;
          end
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = PhSkip;
            skip_d  = 2'd2;
          end
        end
        PhSkip: begin
          // trailing crlf of the chunk, taken without checking
          if (skip_q <= 2'd1) begin
            skip_d        = 2'd0;
            phase_d       = PhSize;
            left_d        = '0;
            digits_done_d = 1'b0;
            saw_cr_d      = 1'b0;
          end else begin
            skip_d = skip_q - 2'd1;
          end
        end
        default: begin
          // done: byte dropped, no result
        end
      endcase

      // body cut short before the zero chunk
      if (phase_q != PhDone && in_last_q && !r_end) begin
        emit     = 1'b1;
        r_end    = 1'b1;
        r_status = 1'b1;
        phase_d  = PhDone;
      end
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (proc_go) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (proc_go && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      phase_q       <= PhSize;
      left_q        <= '0;
      digits_done_q <= 1'b0;
      saw_cr_q      <= 1'b0;
      skip_q        <= 2'd0;
    end else begin
      in_valid_q    <= in_valid_d;
      out_valid_q   <= out_valid_d;
      phase_q       <= phase_d;
      left_q        <= left_d;
      digits_done_q <= digits_done_d;
      saw_cr_q      <= saw_cr_d;
      skip_q        <= skip_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (proc_go && emit) begin
      out_byte_q   <= r_byte;
      out_has_q    <= r_has;
      out_end_q    <= r_end;
      out_status_q <= r_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_end_q;
  always_comb begin
    m_axis_tuser              = '0;
    m_axis_tuser[UserHasByte] = out_has_q;
    m_axis_tuser[UserStatus]  = out_status_q;
  end

endmodule

@@ rtl/hcbd_checker.sv @@
// ----------------------------------------------------------------------------
// hcbd_checker
// port-level checks on the chunked body decoder result stream
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_core_macros.svh"

module hcbd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [hcbd_pkg::ByteW-1:0]  m_axis_tdata,
  input logic [hcbd_pkg::UserW-1:0]  m_axis_tuser,
  input logic                        m_axis_tlast
);
  import hcbd_pkg::*;

  logic end_seen_q;

  // sticky once the end result has been taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_seen_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tlast) begin
      end_seen_q <= 1'b1;
    end
  end

  `HCBD_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
  `HCBD_ASSERT(a_no_empty, clk_i, rst_ni, !m_axis_tvalid || m_axis_tuser[UserHasByte] || m_axis_tlast, "result with neither byte nor end")
  `HCBD_ASSERT(a_status_end, clk_i, rst_ni, !(m_axis_tvalid && m_axis_tuser[UserStatus]) || m_axis_tlast, "truncated status without end")
  `HCBD_ASSERT(a_zero_byte, clk_i, rst_ni, !(m_axis_tvalid && !m_axis_tuser[UserHasByte]) || m_axis_tdata == '0, "data nonzero without payload byte")
  `HCBD_ASSERT(a_after_end, clk_i, rst_ni, !(end_seen_q && m_axis_tvalid), "result after end of body")

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ tb/sv/tb_http_chunked_body_decoder_core.sv @@
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder_core
// self-checking bench for the chunked body decoder: a short table of framing
// corner cases, then random well-formed chunks with noisy size lines and
// trailers, closed by one randomly chosen body ending. every result request
// is checked against a pinned result or the in-bench model, field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_http_chunked_body_decoder_core;
  import hcbd_pkg::*;

  localparam int unsigned SizeW        = SizeBitsDefault;
  localparam int unsigned TableRows    = 20;
  localparam int unsigned RandomBudget = 650;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned SettleCycles = 16;

  localparam logic [ByteW-1:0] CharSemi  = 8'h3B;
  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] CharSpace = 8'h20;
  localparam logic [ByteW-1:0] CharStar  = 8'h2A;

  // one decoded result, as the core reports it
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             has_byte;
    logic             body_end;
    logic             truncated;
  } dec_result_t;

  // one row of the directed table; pinned rows carry their result typed in
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             pinned;
    dec_result_t      want;
  } stim_row_t;

  typedef enum logic [1:0] {ScanSize, CopyData, SkipTrailer, BodyDone} parse_state_e;
  typedef enum logic [1:0] {
    CloseZeroChunk, CloseEmptyLine, ClosePayloadCut, CloseSizeCut
  } body_close_e;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [ByteW-1:0] s_axis_tdata  = '0;
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [ByteW-1:0] m_axis_tdata;
  logic [UserW-1:0] m_axis_tuser;
  logic             m_axis_tlast;

  http_chunked_body_decoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // decoder model state
  parse_state_e     parse_state  = ScanSize;
  logic [SizeW-1:0] chunk_left   = '0;
  logic             digits_shut  = 1'b0;
  logic             cr_pending   = 1'b0;
  logic [1:0]       trailer_left = '0;

  dec_result_t pending_results[$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned bytes_sent     = 0;
  int unsigned chunk_total    = 0;
  int unsigned payload_seen   = 0;
  int unsigned ends_seen      = 0;
  int unsigned fault_count    = 0;
  int unsigned quiet_cycles   = 0;
  string       close_label    = "none";

  stim_row_t framing_rows [0:TableRows-1];

  // ascii hex digit value, -1 for anything else
  function automatic int hex_nibble(input logic [ByteW-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
    return -1;
  endfunction

  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return CharZero + nib;
    return (upper ? 8'h41 : 8'h61) + nib - 4'd10;
  endfunction

  // advance the decoder model by one byte; returns 1 when a result is due
  function automatic bit decode_byte(input logic [ByteW-1:0] b, input logic is_last,
                                     output dec_result_t r);
    int              nib;
    logic [SizeW+3:0] grown;
    bit              hit;
    r   = '0;
    hit = 1'b0;
    if (parse_state == BodyDone) return 1'b0;
    case (parse_state)
      ScanSize: begin
        if (cr_pending && b == CharLf) begin
          cr_pending  = 1'b0;
          digits_shut = 1'b0;
          if (chunk_left == '0) begin
            parse_state = BodyDone;
            hit         = 1'b1;
            r.body_end  = 1'b1;
          end else begin
            parse_state = CopyData;
          end
        end else begin
          nib = hex_nibble(b);
          if (!digits_shut && nib >= 0) begin
            grown      = {chunk_left, nib[3:0]};
            chunk_left = (grown[SizeW+3:SizeW] != '0) ? '1 : grown[SizeW-1:0];
          end else begin
            digits_shut = 1'b1;
          end
          cr_pending = (b == CharCr);
        end
      end
      CopyData: begin
        if (chunk_left != '0) begin
          hit        = 1'b1;
          r.has_byte = 1'b1;
          r.data     = b;
          chunk_left = chunk_left - 1'b1;
        end
        if (chunk_left == '0) begin
          parse_state  = SkipTrailer;
          trailer_left = 2'd2;
        end
      end
      SkipTrailer: begin
        if (trailer_left != '0) trailer_left = trailer_left - 1'b1;
        if (trailer_left == '0) begin
          parse_state = ScanSize;
          chunk_left  = '0;
          digits_shut = 1'b0;
          cr_pending  = 1'b0;
        end
      end
      BodyDone: ;
    endcase
    // in_last closes the body early unless this byte already closed it
    if (is_last && !r.body_end) begin
      hit         = 1'b1;
      r.body_end  = 1'b1;
      r.truncated = 1'b1;
      parse_state = BodyDone;
    end
    return hit;
  endfunction

  // offer one byte, wait for its handshake, then book the expected result
  task automatic send_byte(input logic [ByteW-1:0] b, input logic is_last,
                           input logic pinned = 1'b0, input dec_result_t want = '0);
    dec_result_t predicted;
    bit          due;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    due = decode_byte(b, is_last, predicted);
    if (pinned) pending_results.push_back(want);
    else if (due) pending_results.push_back(predicted);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // size line: optional leading zeros, digits in mixed case, optional
  // extension, sometimes a lone cr or a doubled cr before the terminator
  task automatic send_size_line(input logic [31:0] size_val);
    int unsigned      ndig;
    logic [ByteW-1:0] b;
    ndig = 1;
    while (ndig < 8 && (size_val >> (4 * ndig)) != 0) ndig++;
    if ($urandom_range(99) < 20) repeat ($urandom_range(3, 1)) send_byte(CharZero, 1'b0);
    for (int i = ndig - 1; i >= 0; i--) begin
      send_byte(hex_char(size_val[4*i +: 4], 1'($urandom_range(1))), 1'b0);
    end
    if ($urandom_range(99) < 25) begin
      send_byte(CharSemi, 1'b0);
      repeat ($urandom_range(6, 1)) begin
        b = 8'($urandom_range(255));
        if (b == CharCr) b = CharSpace;
        send_byte(b, 1'b0);
      end
    end
    if ($urandom_range(99) < 15) begin
      b = 8'($urandom_range(255));
      if (b == CharCr || b == CharLf) b = CharStar;
      send_byte(CharCr, 1'b0);
      send_byte(b, 1'b0);
    end
    if ($urandom_range(99) < 10) send_byte(CharCr, 1'b0);
    send_byte(CharCr, 1'b0);
    send_byte(CharLf, 1'b0);
  endtask

  task automatic send_chunk();
    logic [31:0] len;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70)      len = $urandom_range(16, 1);
    else if (pick < 95) len = $urandom_range(64, 17);
    else                len = $urandom_range(300, 65);
    send_size_line(len);
    repeat (len) send_byte(8'($urandom_range(255)), 1'b0);
    // trailer is skipped unchecked, so garbage here keeps framing intact
    if ($urandom_range(99) < 85) begin
      send_byte(CharCr, 1'b0);
      send_byte(CharLf, 1'b0);
    end else begin
      repeat (2) send_byte(8'($urandom_range(255)), 1'b0);
    end
    chunk_total++;
  endtask

  // the body ends once per run; which way is up to the seed
  task automatic close_body();
    body_close_e how;
    how = body_close_e'($urandom_range(3));
    case (how)
      CloseZeroChunk: begin
        close_label = "zero chunk with in_last on its lf";
        repeat ($urandom_range(3, 1)) send_byte(CharZero, 1'b0);
        if ($urandom_range(1)) send_byte(CharSemi, 1'b0);
        send_byte(CharCr, 1'b0);
        send_byte(CharLf, 1'b1);
      end
      CloseEmptyLine: begin
        close_label = "size line without digits";
        if ($urandom_range(1)) send_byte(CharSemi, 1'b0);
        send_byte(CharCr, 1'b0);
        send_byte(CharLf, 1'b0);
      end
      ClosePayloadCut: begin
        close_label = "saturated size cut inside payload";
        repeat ($urandom_range(12, 9))
          send_byte(hex_char(4'hF, 1'($urandom_range(1))), 1'b0);
        send_byte(CharCr, 1'b0);
        send_byte(CharLf, 1'b0);
        repeat ($urandom_range(11)) send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(8'($urandom_range(255)), 1'b1);
      end
      default: begin
        close_label = "body cut inside a size line";
        send_byte(hex_char(4'h1, 1'b0), 1'b0);
        send_byte(hex_char(4'hA, 1'($urandom_range(1))), 1'b1);
      end
    endcase
    // everything after the end is ignored, in_last included
    repeat (5) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  // receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    dec_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tuser[UserHasByte]) payload_seen++;
      if (m_axis_tlast) ends_seen++;
      if (pending_results.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result data=%h user=%b last=%b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.data) begin
          fault_count++;
          $display("%0t: out_byte expected %h actual %h", $time, want.data, m_axis_tdata);
        end
        if (m_axis_tuser[UserHasByte] !== want.has_byte) begin
          fault_count++;
          $display("%0t: out_has_byte expected %b actual %b", $time, want.has_byte,
                   m_axis_tuser[UserHasByte]);
        end
        if (m_axis_tlast !== want.body_end) begin
          fault_count++;
          $display("%0t: out_end expected %b actual %b", $time, want.body_end, m_axis_tlast);
        end
        if (m_axis_tuser[UserStatus] !== want.truncated) begin
          fault_count++;
          $display("%0t: out_status expected %b actual %b", $time, want.truncated,
                   m_axis_tuser[UserStatus]);
        end
      end
    end
  end

  // watchdog: too long without any handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, StallLimit);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned stage;
    // size 3 with a digit after a non-hex byte and a lone cr, three payload
    // bytes (00, ff and an lf), garbage trailer; then size 1 with an empty
    // extension and a normal trailer
    framing_rows = '{
      '{CharZero, 1'b0, 1'b0, '0},
      '{8'h33,    1'b0, 1'b0, '0},
      '{8'h47,    1'b0, 1'b0, '0},
      '{8'h66,    1'b0, 1'b0, '0},
      '{CharCr,   1'b0, 1'b0, '0},
      '{8'h78,    1'b0, 1'b0, '0},
      '{CharCr,   1'b0, 1'b0, '0},
      '{CharLf,   1'b0, 1'b0, '0},
      '{8'h00,    1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
      '{8'hFF,    1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
      '{CharLf,   1'b0, 1'b1, '{CharLf, 1'b1, 1'b0, 1'b0}},
      '{8'h5A,    1'b0, 1'b0, '0},
      '{8'h39,    1'b0, 1'b0, '0},
      '{8'h31,    1'b0, 1'b0, '0},
      '{CharSemi, 1'b0, 1'b0, '0},
      '{CharCr,   1'b0, 1'b0, '0},
      '{CharLf,   1'b0, 1'b0, '0},
      '{8'h80,    1'b0, 1'b1, '{8'h80, 1'b1, 1'b0, 1'b0}},
      '{CharCr,   1'b0, 1'b0, '0},
      '{CharLf,   1'b0, 1'b0, '0}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < TableRows; i++) begin
      send_byte(framing_rows[i].data, framing_rows[i].last, framing_rows[i].pinned,
                framing_rows[i].want);
    end
    chunk_total += 2;

    // hold off until every booked result has been taken
    drain_results();

    while (bytes_sent < TableRows + RandomBudget) begin
      stage = (bytes_sent - TableRows) * 4 / RandomBudget;
      case (stage)
        0:       begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
        1:       begin src_idle_pct = 61; sink_stall_pct <= 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct <= 61; end
        default: begin src_idle_pct = 17; sink_stall_pct <= 17; end
      endcase
      send_chunk();
    end
    close_body();

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);

    $display("sent %0d bytes in %0d chunks; %0d payload results, %0d end results",
             bytes_sent, chunk_total, payload_seen, ends_seen);
    $display("body closed by %s, %0d mismatches", close_label, fault_count);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/hcbd_pkg.sv
rtl/http_chunked_body_decoder_core.sv
rtl/hcbd_checker.sv
tb/sv/tb_http_chunked_body_decoder_core.sv
